### rtl/quadrature_tone_injector_assert.svh
// Assertion macros used by the tone injector checker.
`ifndef QUADRATURE_TONE_INJECTOR_ASSERT_SVH
`define QUADRATURE_TONE_INJECTOR_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define QTI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define QTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### rtl/qti_pkg.sv
// Shared types, constants and table generation for the quadrature tone injector.
package qti_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int AMP_W       = 15;
   localparam int STEP_W      = 32;

   // pi in Q30
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP     = 2'd0,
      CSR_TONE_AMPLITUDE = 2'd1,
      CSR_START_PHASE    = 2'd2
   } csr_reg_type;

   // Q30 sine of x on (0, pi/2), Taylor terms up to x^15, truncating divides
   function automatic longint unsigned sine_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned prod;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         prod = (term * x2) >> 30;
         case (n)
            1: term = prod / 6;
            2: term = prod / 20;
            3: term = prod / 42;
            4: term = prod / 72;
            5: term = prod / 110;
            6: term = prod / 156;
            default: term = prod / 210;
         endcase
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Quarter-wave entry k: sine at the middle of slot k, scaled to full scale
   function automatic longint unsigned table_entry(input int k, input int table_bits,
                                                   input int sample_bits);
      longint unsigned x;
      longint unsigned s;
      longint unsigned v;
      longint unsigned fs;
      fs = (64'd1 << (sample_bits - 1)) - 64'd1;
      x  = (PI_Q30 * (2 * longint'(k) + 1)) >> table_bits;
      s  = sine_q30(x);
      v  = (s * fs + (64'd1 << 29)) >> 30;
      if (v > fs) begin
         v = fs;
      end
      return v;
   endfunction

endpackage

### rtl/qti_req_if.sv
// Request channel carrying one I/Q sample pair.
interface qti_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_i;
   logic signed [SAMPLE_BITS-1:0] in_q;

   modport source (output valid, output in_i, output in_q, input ready);
   modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

### rtl/qti_rsp_if.sv
// Response channel carrying one I/Q sample pair with the tone added.
interface qti_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_i;
   logic signed [SAMPLE_BITS-1:0] out_q;

   modport source (output valid, output out_i, output out_q, input ready);
   modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

### rtl/qti_csr_if.sv
// Register write channel.
interface qti_csr_if
   import qti_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/quadrature_tone_injector.sv
// Quadrature tone injector: NCO tone from a quarter-wave ROM added to an I/Q stream.
//
//   channel   dir   handshake     payload
//   req_bus   in    valid/ready   in_i, in_q     (signed, SAMPLE_BITS)
//   rsp_bus   out   valid/ready   out_i, out_q   (signed, SAMPLE_BITS)
//   csr_bus   in    valid/ready   index, wdata   (0 step, 1 amplitude, 2 start phase)
//
// One request per cycle unless back-pressure on rsp_bus stalls the pipeline.
// The stages are ROM read, amplitude multiply, round/add/saturate into the output register.
// Reset clears the valid bits, the accumulator, step and amplitude (not the data registers);
// the ROM is constant. Back-pressure on rsp_bus stalls only the stages behind a full one,
// so bubbles collapse. csr_bus is always ready; a start phase write loads the accumulator at once.
module quadrature_tone_injector
   import qti_pkg::*;
#(
   parameter int TABLE_BITS  = 10,
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   qti_req_if.sink    req_bus,
   qti_rsp_if.source  rsp_bus,
   qti_csr_if.sink    csr_bus
);

   localparam int QUARTER_BITS = TABLE_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam int MAG_W        = SAMPLE_BITS - 1;
   localparam int PROD_W       = MAG_W + AMP_W;
   localparam int SUM_W        = SAMPLE_BITS + 2;

   typedef logic [MAG_W-1:0] rom_type [QUARTER_LEN];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k < QUARTER_LEN; k++) begin
         rom[k] = MAG_W'(table_entry(k, TABLE_BITS, SAMPLE_BITS));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration and phase
   logic [STEP_W-1:0]     phase_step_ff;
   logic [AMP_W-1:0]      amp_ff;
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;

   // stage 1: ROM read
   logic                          v1_ff;
   logic [MAG_W-1:0]              sin_mag_ff, cos_mag_ff;
   logic                          sin_neg1_ff, cos_neg1_ff;
   logic signed [SAMPLE_BITS-1:0] i1_ff, q1_ff;

   // stage 2: product
   logic                          v2_ff;
   logic [PROD_W-1:0]             sin_prod_ff, cos_prod_ff;
   logic                          sin_neg2_ff, cos_neg2_ff;
   logic signed [SAMPLE_BITS-1:0] i2_ff, q2_ff;

   // output register
   logic                          vo_ff;
   logic signed [SAMPLE_BITS-1:0] out_i_ff, out_q_ff;
   logic signed [SAMPLE_BITS-1:0] out_i_in, out_q_in;

   logic load_o, load2, load1, accept;
   logic start_load;

   logic [TABLE_BITS-1:0]   p;
   logic [1:0]              quad;
   logic [QUARTER_BITS-1:0] r;
   logic [QUARTER_BITS-1:0] sin_idx, cos_idx;

   assign load_o = !vo_ff || rsp_bus.ready;
   assign load2  = !v2_ff || load_o;
   assign load1  = !v1_ff || load2;
   assign accept = req_bus.valid && load1;

   assign req_bus.ready = load1;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = vo_ff;
   assign rsp_bus.out_i = out_i_ff;
   assign rsp_bus.out_q = out_q_ff;

   assign start_load = csr_bus.valid && (csr_reg_type'(csr_bus.index) == CSR_START_PHASE);

   // phase of this request and the quarter-wave addresses; cosine is one quadrant ahead
   assign acc_in  = acc_ff + PHASE_BITS'(phase_step_ff);
   assign p       = acc_in[PHASE_BITS-1 -: TABLE_BITS];
   assign quad    = p[TABLE_BITS-1 -: 2];
   assign r       = p[QUARTER_BITS-1:0];
   assign sin_idx = quad[0] ? ~r : r;
   assign cos_idx = quad[0] ? r : ~r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amp_ff        <= '0;
         acc_ff        <= '0;
      end else begin
         if (start_load) begin
            acc_ff <= PHASE_BITS'(csr_bus.wdata);
         end else if (accept) begin
            acc_ff <= acc_in;
         end
         if (csr_bus.valid) begin
            case (csr_reg_type'(csr_bus.index))
               CSR_PHASE_STEP:     phase_step_ff <= STEP_W'(csr_bus.wdata);
               CSR_TONE_AMPLITUDE: amp_ff        <= AMP_W'(csr_bus.wdata);
               // accumulator load handled above
               CSR_START_PHASE:    ;
               default: ;
            endcase
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= req_bus.valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load_o) begin
            vo_ff <= v2_ff;
         end
      end
   end

   // stage 1: synchronous ROM reads
   always_ff @(posedge clock) begin
      if (load1) begin
         sin_mag_ff  <= SINE_ROM[sin_idx];
         cos_mag_ff  <= SINE_ROM[cos_idx];
         sin_neg1_ff <= quad[1];
         cos_neg1_ff <= quad[1] ^ quad[0];
         i1_ff       <= req_bus.in_i;
         q1_ff       <= req_bus.in_q;
      end
   end

   // stage 2: scale by amplitude
   always_ff @(posedge clock) begin
      if (load2) begin
         sin_prod_ff <= PROD_W'(sin_mag_ff) * PROD_W'(amp_ff);
         cos_prod_ff <= PROD_W'(cos_mag_ff) * PROD_W'(amp_ff);
         sin_neg2_ff <= sin_neg1_ff;
         cos_neg2_ff <= cos_neg1_ff;
         i2_ff       <= i1_ff;
         q2_ff       <= q1_ff;
      end
   end

   // round half away from zero on the magnitude, add sign, then clamp
   function automatic logic signed [SAMPLE_BITS-1:0] add_tone(
      input logic signed [SAMPLE_BITS-1:0] sample,
      input logic [PROD_W-1:0]             prod,
      input logic                          neg
   );
      logic [PROD_W-1:0]        rounded;
      logic signed [SUM_W-1:0]  tone;
      logic signed [SUM_W-1:0]  sum;
      rounded = prod + PROD_W'(1 << (AMP_W - 1));
      tone    = SUM_W'(rounded[PROD_W-1:AMP_W]);
      if (neg) begin
         tone = -tone;
      end
      sum = SUM_W'(sample) + tone;
      if (sum[SUM_W-1 -: 3] == 3'b000 || sum[SUM_W-1 -: 3] == 3'b111) begin
         return sum[SAMPLE_BITS-1:0];
      end else if (sum[SUM_W-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   assign out_i_in = add_tone(i2_ff, cos_prod_ff, cos_neg2_ff);
   assign out_q_in = add_tone(q2_ff, sin_prod_ff, sin_neg2_ff);

   always_ff @(posedge clock) begin
      if (load_o) begin
         out_i_ff <= out_i_in;
         out_q_ff <= out_q_in;
      end
   end

endmodule

### rtl/qti_checker.sv
// Port-level checker for the quadrature tone injector and its bind.
`include "quadrature_tone_injector_assert.svh"

module qti_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] out_i,
   input logic [SAMPLE_BITS-1:0] out_q,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   `QTI_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response valid after reset")

   // with the output register free every stage can move, so a request is taken
   `QTI_ASSERT(a_ready_when_drained, clock, reset, req_valid && !rsp_valid |-> req_ready, "request stalled")

   `QTI_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_i) && $stable(out_q), "stalled response changed")

   `QTI_ASSERT(a_csr_always_ready, clock, reset, csr_valid |-> csr_ready, "register write stalled")

endmodule

bind quadrature_tone_injector qti_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_qti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_i     (rsp_bus.out_i),
   .out_q     (rsp_bus.out_q),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);
